// ===== hw/rtl/phv2_pkg.sv =====
// Shared types, constants and status codes for the PROXY v2 header parser.
`timescale 1ns / 1ps
`default_nettype none
package phv2_pkg;

    localparam int unsigned CountWidth = 17;
    localparam logic [16:0] CountMax = 17'h1FFFF;
    localparam logic [16:0] MaxTotalReset = 17'd65551;
    localparam logic [7:0]  IdTypeReset = 8'd224;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned TdataOutWidth = 104;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_TOTAL = 2'd0;
    localparam logic [1:0] CFG_ALLOW_ID  = 2'd1;
    localparam logic [1:0] CFG_ID_TYPE   = 2'd2;

    // Status codes in check order; ID_DUP/ID_INVALID are checked before TLV_HDR/VALUE.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_SIGNATURE   = 4'd2;
    localparam logic [3:0] ST_VERSION     = 4'd3;
    localparam logic [3:0] ST_TOO_LONG    = 4'd4;
    localparam logic [3:0] ST_LENGTH      = 4'd5;
    localparam logic [3:0] ST_COMMAND     = 4'd6;
    localparam logic [3:0] ST_FAMILY      = 4'd7;
    localparam logic [3:0] ST_ADDR_TRUNC  = 4'd8;
    localparam logic [3:0] ST_TLV_HDR     = 4'd9;
    localparam logic [3:0] ST_TLV_VALUE   = 4'd10;
    localparam logic [3:0] ST_ID_DUP      = 4'd11;
    localparam logic [3:0] ST_ID_INVALID  = 4'd12;
    localparam logic [3:0] ST_NO_ID       = 4'd13;
    localparam logic [3:0] ST_ID_NOT_UNSP = 4'd14;

    // Family bytes and kinds.
    localparam logic [7:0] FAM_UNSPEC = 8'h00;
    localparam logic [7:0] FAM_TCP4   = 8'h11;
    localparam logic [7:0] FAM_TCP6   = 8'h21;
    localparam logic [1:0] KIND_UNSPEC = 2'd0;
    localparam logic [1:0] KIND_TCP4   = 2'd1;
    localparam logic [1:0] KIND_TCP6   = 2'd2;

    // TLV walk phases.
    localparam logic [1:0] TLV_TYPE  = 2'd0;
    localparam logic [1:0] TLV_LEN_H = 2'd1;
    localparam logic [1:0] TLV_LEN_L = 2'd2;
    localparam logic [1:0] TLV_VALUE = 2'd3;

    // One finished preamble, ready to be turned into result transfers.
    typedef struct packed {
        logic [3:0]       status;
        logic [1:0]       family_kind;
        logic             has_identity;
        logic [15:0]      src_port;
        logic [15:0]      dest_port;
        logic [7:0][63:0] words;
    } phv2_summary_t;

    // Fixed signature bytes.
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0, 4'd2:               r = 8'h0d;
            4'd1, 4'd3, 4'd6, 4'd11:  r = 8'h0a;
            4'd4:                     r = 8'h00;
            4'd5:                     r = 8'h0d;
            4'd7:                     r = 8'h51;
            4'd8:                     r = 8'h55;
            4'd9:                     r = 8'h49;
            4'd10:                    r = 8'h54;
            default:                  r = 8'h00;
        endcase
        return r;
    endfunction

    // Address block length for a family byte.
    function automatic logic [5:0] addr_len(input logic [7:0] fam);
        logic [5:0] r;
        if (fam == FAM_TCP4) begin
            r = 6'd12;
        end else if (fam == FAM_TCP6) begin
            r = 6'd36;
        end else begin
            r = 6'd0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/phv2_front.sv =====
// Byte parser: checks the header, captures fields, walks TLVs, builds a summary.
`timescale 1ns / 1ps
`default_nettype none
module phv2_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   byte_accept,
    input  wire [7:0]             data_byte,
    input  wire                   end_of_preamble,
    input  wire [16:0]            max_total_bytes,
    input  wire                   allow_identity,
    input  wire [7:0]             identity_tlv_type,
    output logic                  push,
    output phv2_pkg::phv2_summary_t push_data
);
    import phv2_pkg::*;

    logic [16:0] cnt_reg, cnt_next;
    logic [16:0] exp_reg, exp_next;
    logic [3:0]  herr_reg, herr_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  fam_reg, fam_next;
    logic [1:0][63:0] src_reg, src_next;
    logic [1:0][63:0] dst_reg, dst_next;
    logic [1:0][15:0] port_reg, port_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  terr_reg, terr_next;
    logic        seen_reg, seen_next;
    logic [3:0][63:0] idw_reg, idw_next;
    logic        len33_reg, len33_next;
    logic        ver_reg, ver_next;

    logic [16:0] q;
    logic [5:0]  alen;
    logic [5:0]  off;
    logic [5:0]  offm1;
    logic        do_finish;
    logic [3:0]  st;
    logic [1:0]  fk;

    // Next-state logic for one accepted byte.
    always_comb begin
        cnt_next = cnt_reg;   exp_next = exp_reg;   herr_next = herr_reg;
        cmd_next = cmd_reg;   fam_next = fam_reg;   src_next = src_reg;
        dst_next = dst_reg;   port_next = port_reg; phase_next = phase_reg;
        kind_next = kind_reg; rem_next = rem_reg;   terr_next = terr_reg;
        seen_next = seen_reg; idw_next = idw_reg;   len33_next = len33_reg;
        ver_next = ver_reg;
        q = cnt_reg - 17'd16;
        alen = addr_len(fam_reg);
        off = 6'd0;
        offm1 = 6'd0;
        do_finish = 1'b0;
        st = ST_OK;
        fk = KIND_UNSPEC;
        push = 1'b0;
        push_data = '0;
        if (byte_accept) begin
            if (cnt_reg < 17'd12) begin
                if (data_byte != sig_byte(cnt_reg[3:0]) && herr_reg == ST_OK) begin
                    herr_next = ST_SIGNATURE;
                end
            end else if (cnt_reg == 17'd12) begin
                cmd_next = data_byte;
                if (data_byte[7:4] != 4'h2 && herr_reg == ST_OK) begin
                    herr_next = ST_VERSION;
                end
            end else if (cnt_reg == 17'd13) begin
                fam_next = data_byte;
            end else if (cnt_reg == 17'd14) begin
                exp_next = {1'b0, data_byte, 8'h00};
            end else if (cnt_reg == 17'd15) begin
                exp_next = 17'd16 + {1'b0, exp_reg[15:8], data_byte};
            end else if (cnt_reg != CountMax) begin
                if (q < {11'd0, alen}) begin
                    // Address block capture.
                    if (fam_reg == FAM_TCP4) begin
                        if (q[5:0] < 6'd4) begin
                            src_next[0] = {src_reg[0][55:0], data_byte};
                        end else if (q[5:0] < 6'd8) begin
                            dst_next[0] = {dst_reg[0][55:0], data_byte};
                        end else if (q[5:0] < 6'd10) begin
                            port_next[0] = {port_reg[0][7:0], data_byte};
                        end else begin
                            port_next[1] = {port_reg[1][7:0], data_byte};
                        end
                    end else begin
                        if (q[5:0] < 6'd16) begin
                            src_next[q[3]] = {src_reg[q[3]][55:0], data_byte};
                        end else if (q[5:0] < 6'd32) begin
                            dst_next[q[3]] = {dst_reg[q[3]][55:0], data_byte};
                        end else if (q[5:0] < 6'd34) begin
                            port_next[0] = {port_reg[0][7:0], data_byte};
                        end else begin
                            port_next[1] = {port_reg[1][7:0], data_byte};
                        end
                    end
                end else begin
                    // TLV walk.
                    unique case (phase_reg)
                        TLV_TYPE: begin
                            kind_next = data_byte;
                            phase_next = TLV_LEN_H;
                        end
                        TLV_LEN_H: begin
                            rem_next = {data_byte, 8'h00};
                            phase_next = TLV_LEN_L;
                        end
                        TLV_LEN_L: begin
                            rem_next = {rem_reg[15:8], data_byte};
                            len33_next = (rem_next == 16'd33);
                            ver_next = 1'b0;
                            if (rem_next == 16'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                phase_next = TLV_VALUE;
                            end
                        end
                        default: begin
                            if (len33_reg && kind_reg == identity_tlv_type
                                && rem_reg <= 16'd33) begin
                                off = 6'd33 - rem_reg[5:0];
                                offm1 = off - 6'd1;
                                if (off == 6'd0) begin
                                    ver_next = (data_byte == 8'd1);
                                end else begin
                                    idw_next[offm1[4:3]] =
                                        {idw_reg[offm1[4:3]][55:0], data_byte};
                                end
                            end
                            rem_next = rem_reg - 16'd1;
                            if (rem_next == 16'd0) begin
                                do_finish = 1'b1;
                            end
                        end
                    endcase
                    if (do_finish) begin
                        if (terr_next == ST_OK && kind_next == identity_tlv_type
                            && allow_identity) begin
                            if (seen_next) begin
                                terr_next = ST_ID_DUP;
                            end else if (!(len33_next && ver_next)) begin
                                terr_next = ST_ID_INVALID;
                            end else begin
                                seen_next = 1'b1;
                            end
                        end
                        phase_next = TLV_TYPE;
                    end
                end
            end
            if (cnt_reg != CountMax) begin
                cnt_next = cnt_reg + 17'd1;
            end

            // Final verdict on the last byte.
            if (end_of_preamble) begin
                if (cnt_next < 17'd16) begin
                    st = ST_SHORT;
                end else if (herr_next != ST_OK) begin
                    st = herr_next;
                end else if (exp_next > max_total_bytes) begin
                    st = ST_TOO_LONG;
                end else if (cnt_next != exp_next) begin
                    st = ST_LENGTH;
                end else if (cmd_next[3:0] != 4'h1) begin
                    st = ST_COMMAND;
                end else if (!((fam_next == FAM_UNSPEC && allow_identity)
                               || fam_next == FAM_TCP4 || fam_next == FAM_TCP6)) begin
                    st = ST_FAMILY;
                end else if ((cnt_next - 17'd16) < {11'd0, addr_len(fam_next)}) begin
                    st = ST_ADDR_TRUNC;
                end else if (terr_next != ST_OK) begin
                    st = terr_next;
                end else if (phase_next == TLV_LEN_H || phase_next == TLV_LEN_L) begin
                    st = ST_TLV_HDR;
                end else if (phase_next == TLV_VALUE) begin
                    st = ST_TLV_VALUE;
                end else if (fam_next == FAM_UNSPEC && !seen_next) begin
                    st = ST_NO_ID;
                end else if (seen_next && fam_next != FAM_UNSPEC) begin
                    st = ST_ID_NOT_UNSP;
                end
                fk = (fam_next == FAM_TCP4) ? KIND_TCP4 :
                     (fam_next == FAM_TCP6) ? KIND_TCP6 : KIND_UNSPEC;
                push = 1'b1;
                push_data.status = st;
                if (st == ST_OK) begin
                    push_data.family_kind = fk;
                    push_data.has_identity = seen_next;
                    if (fk != KIND_UNSPEC) begin
                        push_data.src_port = port_next[0];
                        push_data.dest_port = port_next[1];
                        push_data.words[0] = src_next[0];
                        push_data.words[1] = src_next[1];
                        push_data.words[2] = dst_next[0];
                        push_data.words[3] = dst_next[1];
                    end
                    if (seen_next) begin
                        push_data.words[4] = idw_next[0];
                        push_data.words[5] = idw_next[1];
                        push_data.words[6] = idw_next[2];
                        push_data.words[7] = idw_next[3];
                    end
                end
                // Clear run state for the next preamble.
                cnt_next = '0;  exp_next = '0;  herr_next = ST_OK;
                cmd_next = '0;  fam_next = '0;  src_next = '0;
                dst_next = '0;  port_next = '0; phase_next = TLV_TYPE;
                kind_next = '0; rem_next = '0;  terr_next = ST_OK;
                seen_next = 1'b0; idw_next = '0; len33_next = 1'b0;
                ver_next = 1'b0;
            end
        end
    end

    // Run state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;  exp_reg <= '0;  herr_reg <= ST_OK;
            cmd_reg <= '0;  fam_reg <= '0;  src_reg <= '0;
            dst_reg <= '0;  port_reg <= '0; phase_reg <= TLV_TYPE;
            kind_reg <= '0; rem_reg <= '0;  terr_reg <= ST_OK;
            seen_reg <= 1'b0; idw_reg <= '0; len33_reg <= 1'b0;
            ver_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;   exp_reg <= exp_next;   herr_reg <= herr_next;
            cmd_reg <= cmd_next;   fam_reg <= fam_next;   src_reg <= src_next;
            dst_reg <= dst_next;   port_reg <= port_next; phase_reg <= phase_next;
            kind_reg <= kind_next; rem_reg <= rem_next;   terr_reg <= terr_next;
            seen_reg <= seen_next; idw_reg <= idw_next;   len33_reg <= len33_next;
            ver_reg <= ver_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/phv2_queue.sv =====
// Two-entry summary queue between the parser and the result emitter.
`timescale 1ns / 1ps
`default_nettype none
module phv2_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  phv2_pkg::phv2_summary_t push_data,
    input  wire                     pop,
    output phv2_pkg::phv2_summary_t head,
    output logic                    empty,
    output logic                    full
);
    import phv2_pkg::*;

    phv2_summary_t entry_reg [QueueDepth];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/phv2_back.sv =====
// Result emitter: turns a summary into one error transfer or eight word transfers.
`timescale 1ns / 1ps
`default_nettype none
module phv2_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  phv2_pkg::phv2_summary_t head,
    input  wire                     empty,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [103:0]            m_axis_tdata,
    output logic [2:0]              m_axis_tuser,
    output logic                    m_axis_tlast
);
    import phv2_pkg::*;

    logic [2:0]   k_reg;
    logic         valid_reg;
    logic [103:0] data_reg;
    logic [2:0]   user_reg;
    logic         last_reg;
    logic         load;
    logic         final_word;

    assign load = !empty && (!valid_reg || m_axis_tready);
    assign final_word = (head.status != ST_OK) || (k_reg == 3'd7);
    assign pop = load && final_word;

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    // Output register and word counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            k_reg <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                k_reg <= final_word ? 3'd0 : k_reg + 3'd1;
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {1'b0, head.words[k_reg], head.dest_port, head.src_port,
                         head.has_identity, head.family_kind, head.status};
            user_reg <= k_reg;
            last_reg <= final_word;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/proxy_v2_header_parser.sv =====
// PROXY v2 header parser top: one byte per cycle in; a result is queued, then registered
// at the output when the emitter is idle. An error gives one transfer, a good preamble
// eight on consecutive cycles while m_axis_tready is high. Input stalls only while the
// two-entry summary queue is full: output held off, or tiny rejected preambles during a
// good result. Reset (aresetn low, synchronous) clears run state, queue and output;
// config returns to max_total_bytes 65551, allow_identity 0, identity_tlv_type 224.
`timescale 1ns / 1ps
`default_nettype none
module proxy_v2_header_parser (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // data_byte
    input  wire         s_axis_tlast,   // end_of_preamble
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[3:0], family_kind[5:4], has_identity[6], src_port[22:7],
    // dest_port[38:23], word[102:39], zero pad[103]
    output logic [103:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast,   // last
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [1:0]   cfg_index,
    input  wire [16:0]  cfg_data
);
    import phv2_pkg::*;

    logic [16:0]   max_total_reg;
    logic          allow_id_reg;
    logic [7:0]    id_type_reg;
    logic          push, pop, q_empty, q_full, byte_accept;
    phv2_summary_t push_data, head;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !q_full;
    assign byte_accept = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_total_reg <= MaxTotalReset;
            allow_id_reg <= 1'b0;
            id_type_reg <= IdTypeReset;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAX_TOTAL: max_total_reg <= cfg_data;
                CFG_ALLOW_ID:  allow_id_reg <= cfg_data[0];
                CFG_ID_TYPE:   id_type_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    phv2_front u_front (
        .aclk(aclk), .aresetn(aresetn), .byte_accept(byte_accept),
        .data_byte(s_axis_tdata), .end_of_preamble(s_axis_tlast),
        .max_total_bytes(max_total_reg), .allow_identity(allow_id_reg),
        .identity_tlv_type(id_type_reg), .push(push), .push_data(push_data)
    );

    phv2_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_data(push_data),
        .pop(pop), .head(head), .empty(q_empty), .full(q_full)
    );

    phv2_back u_back (
        .aclk(aclk), .aresetn(aresetn), .head(head), .empty(q_empty), .pop(pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // An error result is a single, final transfer at index zero with a zero word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3:0] != ST_OK |->
            m_axis_tlast && m_axis_tuser == 3'd0 && m_axis_tdata[102:39] == 64'd0)
        else $error("error result not single final transfer");

    // A good result ends exactly at word seven.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3:0] == ST_OK |->
            m_axis_tlast == (m_axis_tuser == 3'd7))
        else $error("good result last flag misplaced");

    // Good results step through the word indexes in order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
            m_axis_tuser == $past(m_axis_tuser) + 3'd1)
        else $error("word index skipped");

endmodule
`default_nettype wire
